// ----- rtl/core/gdfr_pkg.sv -----
`default_nettype none
package gdfr_pkg;

  // widest slot index and offset carried between front and back
  localparam int unsigned SLOT_BITS   = 5;
  localparam int unsigned OFF_BITS    = 17;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned HDR_BYTES   = 22;

  // verdict codes; frame status reuses them for the reject cases
  localparam logic [2:0] V_DUMPED   = 3'd0;
  localparam logic [2:0] V_NOTGRE   = 3'd1;
  localparam logic [2:0] V_FILTERED = 3'd2;
  localparam logic [2:0] V_ORPHAN   = 3'd3;
  localparam logic [2:0] V_STORED   = 3'd4;
  localparam logic [2:0] V_FULL     = 3'd5;
  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_ACCEPT  = 3'd6;

  localparam logic [1:0] CFG_SRC = 2'd0;
  localparam logic [1:0] CFG_DST = 2'd1;
  localparam logic [1:0] CFG_KEY = 2'd2;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_GRE = 8'd47;
  localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [15:0] HDR_FIRST = 16'd12;
  localparam logic [15:0] HDR_LAST  = 16'd33;
  localparam logic [15:0] POS_MAX   = 16'hffff;
  localparam logic [16:0] LEN_MAX   = 17'h1_ffff;
  localparam logic [16:0] GRE_HDR   = 17'd8;
  localparam logic [6:0]  ETH_HDR   = 7'd14;

  typedef enum logic [1:0] {
    CL_UNFRAG,
    CL_FIRST,
    CL_MIDDLE,
    CL_LAST
  } class_e;

  typedef struct packed {
    logic                 rd;
    logic                 clr;
    logic                 wr;
    logic                 fin;
    logic [SLOT_BITS-1:0] slot;
    logic [OFF_BITS-1:0]  off;
    logic [7:0]           data;
    logic [2:0]           status;
    class_e               cls;
    logic [15:0]          cnt;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/gdfr_ram.sv -----
`default_nettype none
module gdfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gdfr_queue.sv -----
`default_nettype none
module gdfr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gdfr_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output gdfr_pkg::cmd_t       cmd_o
);

  localparam int unsigned PW = $clog2(gdfr_pkg::QUEUE_DEPTH);

  gdfr_pkg::cmd_t mem_q [gdfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    count_q;

  assign full_o  = (count_q == (PW+1)'(gdfr_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(gdfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(gdfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(gdfr_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/gdfr_front.sv -----
`default_nettype none
module gdfr_front #(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [2:0]  read_slot_i,
  input  wire logic [13:0] read_offset_i,
  input  wire logic [31:0] source_filter_i,
  input  wire logic [31:0] dest_filter_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output gdfr_pkg::cmd_t   q_cmd_o
);

  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam int unsigned TW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0]           pos_q, pos_d;
  logic [2:0]            status_q, status_d;
  gdfr_pkg::class_e      cls_q, cls_d;
  logic [SW-1:0]         cs_q, cs_d;
  logic [16:0]           off_q, off_d;
  logic [15:0]           cnt_q, cnt_d;
  logic [6:0]            pstart_q, pstart_d;
  logic [16:0]           pend_q, pend_d;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic                  rp_active_q, rp_active_d;
  logic [5:0]            rp_pos_q, rp_pos_d;
  logic                  rp_last_q, rp_last_d;

  logic [7:0]            hdr_q [gdfr_pkg::HDR_BYTES];
  logic [7:0]            hv [gdfr_pkg::HDR_BYTES];
  logic [63:0]           tag_q [SLOTS];
  logic [15:0]           ident_q [SLOTS];
  logic                  tbl_we;
  logic [TW-1:0]         tbl_idx;

  logic                  in_fire;
  logic [15:0]           eth;
  logic [3:0]            ihl;
  logic [15:0]           iplen, ident;
  logic                  more;
  logic [12:0]           fo;
  logic [7:0]            proto;
  logic [31:0]           src, dst;
  logic [63:0]           tag;
  logic [6:0]            ps;
  logic                  match_hit, free_hit;
  logic [SW-1:0]         match_idx, free_idx;
  gdfr_pkg::cmd_t        cmd;

  assign in_stall_o = q_full_i || rp_active_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  // header view at classification time: byte 33 is still on the input
  always_comb begin
    for (int k = 0; k < gdfr_pkg::HDR_BYTES; k++) begin
      hv[k] = hdr_q[k];
    end
    hv[gdfr_pkg::HDR_BYTES-1] = data_byte_i;
  end

  assign eth   = {hv[0], hv[1]};
  assign ihl   = hv[2][3:0];
  assign iplen = {hv[4], hv[5]};
  assign ident = {hv[6], hv[7]};
  assign more  = hv[8][5];
  assign fo    = {hv[8][4:0], hv[9]};
  assign proto = hv[11];
  assign src   = {hv[14], hv[15], hv[16], hv[17]};
  assign dst   = {hv[18], hv[19], hv[20], hv[21]};
  assign tag   = {src, dst};
  assign ps    = gdfr_pkg::ETH_HDR + {1'b0, ihl, 2'b00};

  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!match_hit && valid_q[i] && tag_q[i] == tag && ident_q[i] == ident) begin
        match_hit = 1'b1;
        match_idx = SW'(i);
      end
      if (!free_hit && !valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    logic          do_fin;
    logic          acc;
    logic          rp_start;
    logic [7:0]    rb;
    pos_d       = pos_q;
    status_d    = status_q;
    cls_d       = cls_q;
    cs_d        = cs_q;
    off_d       = off_q;
    cnt_d       = cnt_q;
    pstart_d    = pstart_q;
    pend_d      = pend_q;
    valid_d     = valid_q;
    rp_active_d = rp_active_q;
    rp_pos_d    = rp_pos_q;
    rp_last_d   = rp_last_q;
    tbl_we      = 1'b0;
    tbl_idx     = '0;
    cmd         = '0;
    do_fin      = 1'b0;
    acc         = 1'b0;
    rp_start    = 1'b0;
    rb          = hdr_q[5'(rp_pos_q - 6'd12)];

    if (rp_active_q) begin
      // short IHL: payload bytes held in the header are written one a cycle while the queue is not full
      if (!q_full_i) begin
        if ({11'd0, rp_pos_q} < pend_q) begin
          cmd.wr   = 1'b1;
          cmd.slot = gdfr_pkg::SLOT_BITS'(cs_q);
          cmd.off  = off_q;
          cmd.data = rb;
          off_d    = off_q + 17'd1;
          cnt_d    = cnt_q + 16'd1;
        end
        if (rp_pos_q == 6'(gdfr_pkg::HDR_LAST)) begin
          rp_active_d = 1'b0;
          do_fin      = rp_last_q;
        end else begin
          rp_pos_d = rp_pos_q + 6'd1;
        end
      end
    end else if (in_fire) begin
      if (action_i) begin
        cmd.rd   = 1'b1;
        cmd.slot = gdfr_pkg::SLOT_BITS'(read_slot_i);
        cmd.off  = 17'(read_offset_i);
      end else begin
        if (pos_q == gdfr_pkg::HDR_LAST) begin
          if (eth != gdfr_pkg::ETH_IPV4 || proto != gdfr_pkg::PROTO_GRE) begin
            status_d = gdfr_pkg::V_NOTGRE;
          end else if ((source_filter_i != gdfr_pkg::ALL_ONES && source_filter_i != src) ||
                       (dest_filter_i != gdfr_pkg::ALL_ONES && dest_filter_i != dst)) begin
            status_d = gdfr_pkg::V_FILTERED;
          end else if (!more && fo == '0) begin
            acc     = 1'b1;
            cls_d   = gdfr_pkg::CL_UNFRAG;
            cs_d    = SW'(SLOTS);
            cmd.clr = 1'b1;
          end else if (fo == '0) begin
            if (match_hit || free_hit) begin
              acc     = 1'b1;
              cls_d   = gdfr_pkg::CL_FIRST;
              cs_d    = match_hit ? match_idx : free_idx;
              tbl_we  = 1'b1;
              tbl_idx = TW'(cs_d);
              valid_d[TW'(cs_d)] = 1'b1;
              cmd.clr = 1'b1;
            end else begin
              status_d = gdfr_pkg::V_FULL;
            end
          end else if (!match_hit) begin
            status_d = gdfr_pkg::V_ORPHAN;
          end else begin
            acc   = 1'b1;
            cls_d = more ? gdfr_pkg::CL_MIDDLE : gdfr_pkg::CL_LAST;
            cs_d  = match_idx;
          end
          if (acc) begin
            status_d = gdfr_pkg::ST_ACCEPT;
            off_d    = {1'b0, fo, 3'b000};
            cnt_d    = '0;
            pstart_d = ps;
            pend_d   = 17'(gdfr_pkg::ETH_HDR) + {1'b0, iplen};
            cmd.slot = gdfr_pkg::SLOT_BITS'(cs_d);
            if (ps <= 7'(gdfr_pkg::HDR_LAST)) begin
              rp_start    = 1'b1;
              rp_active_d = 1'b1;
              rp_pos_d    = 6'(ps);
              rp_last_d   = last_byte_i;
            end
          end
        end else if (pos_q > gdfr_pkg::HDR_LAST && pos_q != gdfr_pkg::POS_MAX &&
                     status_q == gdfr_pkg::ST_ACCEPT && pos_q >= {9'd0, pstart_q} &&
                     {1'b0, pos_q} < pend_q) begin
          cmd.wr   = 1'b1;
          cmd.slot = gdfr_pkg::SLOT_BITS'(cs_q);
          cmd.off  = off_q;
          cmd.data = data_byte_i;
          off_d    = off_q + 17'd1;
          cnt_d    = cnt_q + 16'd1;
        end
        if (pos_q != gdfr_pkg::POS_MAX) begin
          pos_d = pos_q + 16'd1;
        end
        if (last_byte_i) begin
          if (pos_q < gdfr_pkg::HDR_LAST) begin
            cmd.fin    = 1'b1;
            cmd.status = gdfr_pkg::V_NOTGRE;
            pos_d      = '0;
            status_d   = gdfr_pkg::ST_HEADER;
          end else if (!rp_start) begin
            do_fin = 1'b1;
          end
        end
      end
    end

    if (do_fin) begin
      cmd.fin    = 1'b1;
      cmd.status = status_d;
      cmd.cls    = cls_d;
      cmd.slot   = gdfr_pkg::SLOT_BITS'(cs_d);
      cmd.cnt    = cnt_d;
      if (status_d == gdfr_pkg::ST_ACCEPT && cls_d == gdfr_pkg::CL_LAST) begin
        valid_d[TW'(cs_d)] = 1'b0;
      end
      pos_d    = '0;
      status_d = gdfr_pkg::ST_HEADER;
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = cmd.rd || cmd.clr || cmd.wr || cmd.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      status_q    <= gdfr_pkg::ST_HEADER;
      valid_q     <= '0;
      rp_active_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      status_q    <= status_d;
      valid_q     <= valid_d;
      rp_active_q <= rp_active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q     <= cls_d;
    cs_q      <= cs_d;
    off_q     <= off_d;
    cnt_q     <= cnt_d;
    pstart_q  <= pstart_d;
    pend_q    <= pend_d;
    rp_pos_q  <= rp_pos_d;
    rp_last_q <= rp_last_d;
    if (in_fire && !action_i && pos_q >= gdfr_pkg::HDR_FIRST &&
        pos_q <= gdfr_pkg::HDR_LAST) begin
      hdr_q[5'(pos_q - gdfr_pkg::HDR_FIRST)] <= data_byte_i;
    end
    if (tbl_we) begin
      tag_q[tbl_idx]   <= tag;
      ident_q[tbl_idx] <= ident;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gdfr_back.sv -----
`default_nettype none
module gdfr_back #(
  parameter int unsigned SLOTS     = 4,
  parameter int unsigned BUF_BYTES = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] key_filter_i,
  input  wire logic        q_empty_i,
  input  wire gdfr_pkg::cmd_t q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       verdict_o,
  output logic [2:0]       slot_o,
  output logic [15:0]      payload_length_o,
  output logic [7:0]       read_data_o
);

  localparam int unsigned SW    = $clog2(SLOTS + 1);
  localparam int unsigned OFFW  = $clog2(BUF_BYTES);
  localparam int unsigned AW    = SW + OFFW;
  localparam int unsigned DEPTH = (SLOTS + 1) << OFFW;

  logic [31:0]   key_q [SLOTS + 1];
  logic [16:0]   len_q [SLOTS + 1];

  logic          p1_valid_q;
  logic [2:0]    p1_verdict_q, p1_slot_q;
  logic [15:0]   p1_len_q;
  logic          p1_rdok_q;

  logic          out_valid_q;
  logic [2:0]    out_verdict_q, out_slot_q;
  logic [15:0]   out_len_q;
  logic [7:0]    out_data_q;

  logic          out_take, p1_free, has_res;
  logic [SW-1:0] cs;
  logic          wr_ok, rd_ok, key_byte;
  logic [31:0]   key_cur;
  logic [17:0]   acc_sum;
  logic [16:0]   sum, trim;
  logic          key_we, len_we;
  logic [2:0]    res_verdict, res_slot;
  logic [15:0]   res_len;
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;

  assign out_take = !out_valid_q || !out_stall_i;
  assign p1_free  = !p1_valid_q || out_take;
  assign has_res  = q_cmd_i.rd || q_cmd_i.fin;
  assign q_pop_o  = !q_empty_i && (!has_res || p1_free);

  assign cs       = q_cmd_i.slot[SW-1:0];
  assign wr_ok    = q_cmd_i.off < gdfr_pkg::OFF_BITS'(BUF_BYTES);
  assign rd_ok    = wr_ok && q_cmd_i.slot <= gdfr_pkg::SLOT_BITS'(SLOTS);
  assign key_byte = q_cmd_i.wr && q_cmd_i.off >= 17'd4 && q_cmd_i.off < 17'd8;

  assign ram_we = q_pop_o && q_cmd_i.wr && wr_ok;
  assign ram_re = q_pop_o && q_cmd_i.rd && rd_ok;

  gdfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({cs, q_cmd_i.off[OFFW-1:0]}),
    .wdata_i (q_cmd_i.data),
    .re_i    (ram_re),
    .raddr_i ({cs, q_cmd_i.off[OFFW-1:0]}),
    .rdata_o (ram_rdata)
  );

  // key word: clear on packet start, then big-endian bytes 4..7 of the slot
  always_comb begin
    logic [1:0] lane;
    lane    = 2'd3 - q_cmd_i.off[1:0];
    key_cur = key_q[cs];
    if (q_cmd_i.clr) begin
      key_cur = '0;
    end
    if (key_byte) begin
      key_cur[{lane, 3'b000} +: 8] = q_cmd_i.data;
    end
  end

  assign acc_sum = {1'b0, len_q[cs]} + 18'(q_cmd_i.cnt);

  always_comb begin
    if (q_cmd_i.cls == gdfr_pkg::CL_UNFRAG || q_cmd_i.cls == gdfr_pkg::CL_FIRST) begin
      sum = {1'b0, q_cmd_i.cnt};
    end else if (acc_sum > {1'b0, gdfr_pkg::LEN_MAX}) begin
      sum = gdfr_pkg::LEN_MAX;
    end else begin
      sum = acc_sum[16:0];
    end
    trim = sum - gdfr_pkg::GRE_HDR;
  end

  always_comb begin
    res_verdict = gdfr_pkg::V_DUMPED;
    res_slot    = '0;
    res_len     = '0;
    if (q_cmd_i.fin) begin
      if (q_cmd_i.status != gdfr_pkg::ST_ACCEPT) begin
        res_verdict = q_cmd_i.status;
      end else if (q_cmd_i.cls == gdfr_pkg::CL_FIRST || q_cmd_i.cls == gdfr_pkg::CL_MIDDLE) begin
        res_verdict = gdfr_pkg::V_STORED;
        res_slot    = 3'(cs);
      end else if (key_filter_i == '0 || key_filter_i == key_cur) begin
        res_verdict = gdfr_pkg::V_DUMPED;
        res_slot    = 3'(cs);
        if (sum < gdfr_pkg::GRE_HDR) begin
          res_len = '0;
        end else if (trim[16]) begin
          res_len = 16'hffff;
        end else begin
          res_len = trim[15:0];
        end
      end else begin
        res_verdict = gdfr_pkg::V_FILTERED;
      end
    end
  end

  assign key_we = q_pop_o && (q_cmd_i.clr || (key_byte && wr_ok));
  assign len_we = q_pop_o && q_cmd_i.fin && q_cmd_i.status == gdfr_pkg::ST_ACCEPT;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[cs] <= key_cur;
    end
    if (len_we) begin
      len_q[cs] <= sum;
    end
    if (p1_free) begin
      p1_verdict_q <= res_verdict;
      p1_slot_q    <= res_slot;
      p1_len_q     <= res_len;
      p1_rdok_q    <= q_cmd_i.rd && rd_ok;
    end
    if (out_take) begin
      out_verdict_q <= p1_verdict_q;
      out_slot_q    <= p1_slot_q;
      out_len_q     <= p1_len_q;
      out_data_q    <= p1_rdok_q ? ram_rdata : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_valid_q <= q_pop_o && has_res;
      end
      if (out_take) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = out_verdict_q;
  assign slot_o           = out_slot_q;
  assign payload_length_o = out_len_q;
  assign read_data_o      = out_data_q;

`ifndef ASSERT_OFF
  a_p1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && out_valid_q && out_stall_i |=>
      p1_valid_q && $stable(p1_verdict_q) && $stable(ram_rdata))
    else $error("result stage lost or read data moved under stall");
  a_one_port_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("store write and read from one command");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/gre_decap_frag_reassembly_top.sv -----
`default_nettype none
// A result passes through the command queue, the p1 stage and the output register.
// Throughput: one beat per cycle (frame byte or read) unless stalled; the back end
// writes or reads the packet store once per cycle through its single write and
// single read port. IHL below 5 stalls input after byte 33 to write header payload.
// Reset: asynchronous, active low; filters take their defaults, the slot table is
// emptied, and the packet store is not cleared.
module gre_decap_frag_reassembly_top #(
  parameter int unsigned SLOTS     = 4,
  parameter int unsigned BUF_BYTES = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [2:0]  read_slot_i,
  input  wire logic [13:0] read_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       verdict_o,
  output logic [2:0]       slot_o,
  output logic [15:0]      payload_length_o,
  output logic [7:0]       read_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0]    src_filter_q, dst_filter_q, key_filter_q;
  logic           q_push, q_full, q_pop, q_empty;
  gdfr_pkg::cmd_t q_wcmd, q_rcmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_filter_q <= gdfr_pkg::ALL_ONES;
      dst_filter_q <= gdfr_pkg::ALL_ONES;
      key_filter_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gdfr_pkg::CFG_SRC: src_filter_q <= cfg_data_i;
        gdfr_pkg::CFG_DST: dst_filter_q <= cfg_data_i;
        gdfr_pkg::CFG_KEY: key_filter_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gdfr_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .read_slot_i     (read_slot_i),
    .read_offset_i   (read_offset_i),
    .source_filter_i (src_filter_q),
    .dest_filter_i   (dst_filter_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_wcmd)
  );

  gdfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_rcmd)
  );

  gdfr_back #(
    .SLOTS     (SLOTS),
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_filter_i     (key_filter_q),
    .q_empty_i        (q_empty),
    .q_cmd_i          (q_rcmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .slot_o           (slot_o),
    .payload_length_o (payload_length_o),
    .read_data_o      (read_data_o)
  );

endmodule
`default_nettype wire

// ----- tb/tb_gre_decap_frag_reassembly_top.sv -----
`timescale 1ns / 1ps
module tb_gre_decap_frag_reassembly_top;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned BUF_BYTES = 16384;
  localparam logic [31:0] DEF_SRC   = 32'h0a00_0001;
  localparam logic [31:0] DEF_DST   = 32'h0a00_0002;
  localparam logic [31:0] ALT_SRC   = 32'hc0a8_0101;
  localparam logic [31:0] ALT_DST   = 32'hc0a8_0102;
  localparam logic [31:0] KEY_A     = 32'h1234_5678;
  localparam logic [31:0] KEY_B     = 32'h9abc_def0;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [2:0]  slot;
    logic [15:0] plen;
    logic [7:0]  rdata;
  } res_t;

  typedef enum int {K_GRE, K_SHORT, K_ETH, K_PROTO, K_READ} row_kind_e;

  // for K_READ rows: ident carries the slot, plen the offset; K_SHORT: plen is the frame length
  typedef struct {
    row_kind_e   kind;
    int          ihl;
    bit          mf;
    int          fo;
    int          ident;
    int          plen;
    logic [31:0] key;
    bit          has_exp;
    logic [2:0]  exp_v;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic [2:0]  read_slot_i;
  logic [13:0] read_offset_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  verdict_o;
  logic [2:0]  slot_o;
  logic [15:0] payload_length_o;
  logic [7:0]  read_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  gre_decap_frag_reassembly_top #(
    .SLOTS     (SLOTS),
    .BUF_BYTES (BUF_BYTES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .read_slot_i      (read_slot_i),
    .read_offset_i    (read_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .slot_o           (slot_o),
    .payload_length_o (payload_length_o),
    .read_data_o      (read_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // ---------------- reassembly predictor state ----------------
  logic [31:0] f_src, f_dst, f_key;
  int unsigned bpos;
  logic [7:0]  hdr_b [12:33];
  int unsigned cur;
  logic [2:0]  fstat;
  gdfr_pkg::class_e fcls;
  int unsigned fbase, pstart, pend, pcnt;
  bit          sv [SLOTS];
  logic [63:0] stag [SLOTS];
  logic [15:0] sid [SLOTS];
  int unsigned slen [SLOTS+1];
  logic [31:0] skey [SLOTS+1];
  logic [7:0]  store_mem [int];
  int          written_q [$];

  res_t        verdict_q [$];
  res_t        mon_exp;
  res_t        typed_res;
  bit          typed_on;
  int          errors;
  int          beats_sent;
  bit          quiet;
  bit          hold_req;
  logic [7:0]  frame_q [$];

  function automatic void store_pay(int unsigned pos, logic [7:0] b);
    int unsigned off;
    int          addr;
    if (pos < pstart || pos >= pend) return;
    off = fbase + (pos - pstart);
    if (pcnt < gdfr_pkg::LEN_MAX) pcnt++;
    if (off < BUF_BYTES) begin
      addr = cur * BUF_BYTES + off;
      if (!store_mem.exists(addr)) written_q.push_back(addr);
      store_mem[addr] = b;
      if (off >= 4 && off < 8) skey[cur][(7-off)*8 +: 8] = b;
    end
  endfunction

  function automatic void classify_hdr();
    logic [15:0] eth, ident;
    logic [31:0] src, dst;
    logic [63:0] tag;
    int unsigned ihl, iplen, fo, p;
    bit          more;
    int          m, i;
    eth   = {hdr_b[12], hdr_b[13]};
    src   = {hdr_b[26], hdr_b[27], hdr_b[28], hdr_b[29]};
    dst   = {hdr_b[30], hdr_b[31], hdr_b[32], hdr_b[33]};
    ihl   = hdr_b[14][3:0];
    iplen = {hdr_b[16], hdr_b[17]};
    ident = {hdr_b[18], hdr_b[19]};
    more  = hdr_b[20][5];
    fo    = {hdr_b[20][4:0], hdr_b[21]};
    tag   = {src, dst};
    m     = -1;
    if (eth != gdfr_pkg::ETH_IPV4 || hdr_b[23] != gdfr_pkg::PROTO_GRE) begin
      fstat = gdfr_pkg::V_NOTGRE;
      return;
    end
    if ((f_src != gdfr_pkg::ALL_ONES && f_src != src) ||
        (f_dst != gdfr_pkg::ALL_ONES && f_dst != dst)) begin
      fstat = gdfr_pkg::V_FILTERED;
      return;
    end
    for (i = 0; i < SLOTS; i++)
      if (m < 0 && sv[i] && stag[i] == tag && sid[i] == ident) m = i;
    if (!more && fo == 0) begin
      fcls = gdfr_pkg::CL_UNFRAG;
      cur = SLOTS;
      skey[SLOTS] = '0;
    end else if (fo == 0) begin
      fcls = gdfr_pkg::CL_FIRST;
      if (m < 0)
        for (i = 0; i < SLOTS; i++)
          if (m < 0 && !sv[i]) m = i;
      if (m < 0) begin
        fstat = gdfr_pkg::V_FULL;
        return;
      end
      cur = m;
      sv[m] = 1'b1;
      stag[m] = tag;
      sid[m] = ident;
      skey[m] = '0;
    end else begin
      if (m < 0) begin
        fstat = gdfr_pkg::V_ORPHAN;
        return;
      end
      cur = m;
      fcls = more ? gdfr_pkg::CL_MIDDLE : gdfr_pkg::CL_LAST;
    end
    fstat  = gdfr_pkg::ST_ACCEPT;
    fbase  = fo * 8;
    pstart = 14 + 4 * ihl;
    pend   = 14 + iplen;
    pcnt   = 0;
    // payload that starts inside the fixed header is written now
    for (p = pstart; p <= 33; p++) store_pay(p, hdr_b[p]);
  endfunction

  function automatic res_t close_frame();
    res_t        r;
    int unsigned sum;
    r = '0;
    r.verdict = fstat;
    if (fstat != gdfr_pkg::ST_ACCEPT) return r;
    sum = (fcls == gdfr_pkg::CL_UNFRAG || fcls == gdfr_pkg::CL_FIRST) ? pcnt : slen[cur] + pcnt;
    if (sum > gdfr_pkg::LEN_MAX) sum = gdfr_pkg::LEN_MAX;
    slen[cur] = sum;
    if (fcls == gdfr_pkg::CL_FIRST || fcls == gdfr_pkg::CL_MIDDLE) begin
      r.verdict = gdfr_pkg::V_STORED;
      r.slot = cur[2:0];
      return r;
    end
    if (fcls == gdfr_pkg::CL_LAST) sv[cur % SLOTS] = 1'b0;
    if (f_key == '0 || f_key == skey[cur]) begin
      r.verdict = gdfr_pkg::V_DUMPED;
      r.slot = cur[2:0];
      r.plen = (sum < 8) ? 16'd0 : ((sum - 8 > 65535) ? 16'hffff : 16'(sum - 8));
    end else begin
      r.verdict = gdfr_pkg::V_FILTERED;
    end
    return r;
  endfunction

  function automatic bit reassemble_beat(bit act, logic [7:0] b, bit last, logic [2:0] rs,
                                         logic [13:0] ro, output res_t r);
    int unsigned pos;
    r = '0;
    if (act) begin
      if (rs <= SLOTS && ro < BUF_BYTES && store_mem.exists(rs * BUF_BYTES + ro))
        r.rdata = store_mem[rs * BUF_BYTES + ro];
      return 1'b1;
    end
    pos = bpos;
    if (pos <= 33) begin
      if (pos >= 12) hdr_b[pos] = b;
      if (pos == 33) classify_hdr();
    end else if (pos < 65535 && fstat == gdfr_pkg::ST_ACCEPT) begin
      store_pay(pos, b);
    end
    if (pos < 65535) bpos = pos + 1;
    if (!last) return 1'b0;
    if (pos < 33) r.verdict = gdfr_pkg::V_NOTGRE;
    else r = close_frame();
    bpos  = 0;
    fstat = gdfr_pkg::ST_HEADER;
    return 1'b1;
  endfunction

  // ---------------- frame construction ----------------
  function automatic void build_frame(logic [15:0] eth, logic [7:0] proto, logic [3:0] ihl,
                                      bit mf, logic [12:0] fo, logic [15:0] ident,
                                      logic [31:0] src, logic [31:0] dst, int plen,
                                      logic [31:0] key, int iplen);
    logic [15:0] il;
    int          i;
    logic [2:0]  top;
    il = (iplen < 0) ? 16'(20 + plen) : 16'(iplen);
    top = 3'($urandom);
    frame_q.delete();
    for (i = 0; i < 12; i++) frame_q.push_back(8'($urandom));
    frame_q.push_back(eth[15:8]);
    frame_q.push_back(eth[7:0]);
    frame_q.push_back({4'h4, ihl});
    frame_q.push_back(8'($urandom));
    frame_q.push_back(il[15:8]);
    frame_q.push_back(il[7:0]);
    frame_q.push_back(ident[15:8]);
    frame_q.push_back(ident[7:0]);
    frame_q.push_back({top[1:0], mf, fo[12:8]});
    frame_q.push_back(fo[7:0]);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(proto);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    for (i = 3; i >= 0; i--) frame_q.push_back(src[i*8 +: 8]);
    for (i = 3; i >= 0; i--) frame_q.push_back(dst[i*8 +: 8]);
    for (i = 0; i < plen; i++)
      if (fo == 0 && i >= 4 && i < 8) frame_q.push_back(key[(7-i)*8 +: 8]);
      else frame_q.push_back(8'($urandom));
  endfunction

  // ---------------- drivers ----------------
  task automatic send_beat(bit act, logic [7:0] b, bit last, logic [2:0] rs, logic [13:0] ro);
    int   gap;
    res_t r;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    action_i      = act;
    data_byte_i   = b;
    last_byte_i   = last;
    read_slot_i   = rs;
    read_offset_i = ro;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (reassemble_beat(act, b, last, rs, ro, r)) verdict_q.push_back(typed_on ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic issue_read();
    int a;
    bit keep;
    // a slipped-in read is always checked against the predictor
    keep = typed_on;
    typed_on = 1'b0;
    if (written_q.size() > 0 && $urandom_range(0, 7) != 0) begin
      a = written_q[$urandom_range(0, written_q.size() - 1)];
      send_beat(1'b1, 8'($urandom), 1'($urandom), 3'(a / BUF_BYTES), 14'(a % BUF_BYTES));
    end else begin
      send_beat(1'b1, 8'($urandom), 1'($urandom), 3'($urandom_range(SLOTS + 1, 7)),
                14'($urandom));
    end
    typed_on = keep;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      // reads slipped into the middle of a frame
      if ($urandom_range(0, 99) < 3) issue_read();
      send_beat(1'b0, frame_q[i], i == frame_q.size() - 1, 3'($urandom), 14'($urandom));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gdfr_pkg::CFG_SRC: f_src = val;
      gdfr_pkg::CFG_DST: f_dst = val;
      gdfr_pkg::CFG_KEY: f_key = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr(logic [31:0] def, logic [31:0] alt);
    case ($urandom_range(0, 5))
      0:       return alt;
      1:       return 32'($urandom);
      2:       return '0;
      default: return def;
    endcase
  endfunction

  task automatic frag_packet();
    logic [15:0] ident;
    logic [31:0] src, dst, key;
    logic [12:0] fo;
    int          n, i, plen;
    bit          skipf, skipl;
    ident = 16'($urandom_range(0, 7));
    src   = pick_addr(DEF_SRC, ALT_SRC);
    dst   = pick_addr(DEF_DST, ALT_DST);
    key   = ($urandom_range(0, 1) != 0) ? KEY_A : (($urandom_range(0, 1) != 0) ? KEY_B : 32'($urandom));
    n     = $urandom_range(2, 3);
    skipf = $urandom_range(0, 9) == 0;
    skipl = $urandom_range(0, 11) == 0;
    fo    = '0;
    for (i = 0; i < n; i++) begin
      plen = (i == n - 1) ? $urandom_range(1, 12) : 8;
      if (!((i == 0 && skipf) || (i == n - 1 && skipl))) begin
        build_frame(gdfr_pkg::ETH_IPV4, gdfr_pkg::PROTO_GRE, 4'd5, i != n - 1, fo, ident,
                    src, dst, plen, key, -1);
        send_frame();
      end
      fo = fo + 13'(plen / 8);
      if ($urandom_range(0, 9) == 0) fo = 13'($urandom);
    end
  endtask

  task automatic single_packet();
    int plen, iplen, n;
    plen  = $urandom_range(0, 16);
    iplen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : -1;
    build_frame(gdfr_pkg::ETH_IPV4, gdfr_pkg::PROTO_GRE,
                ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 4)) : 4'd5,
                1'b0, '0, 16'($urandom), pick_addr(DEF_SRC, ALT_SRC), pick_addr(DEF_DST, ALT_DST),
                plen, ($urandom_range(0, 1) != 0) ? KEY_A : 32'($urandom), iplen);
    n = $urandom_range(0, 3);
    repeat (n) frame_q.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic noise_frame();
    int n;
    build_frame(($urandom_range(0, 1) != 0) ? gdfr_pkg::ETH_IPV4 : 16'($urandom),
                ($urandom_range(0, 1) != 0) ? gdfr_pkg::PROTO_GRE : 8'($urandom), 4'($urandom),
                1'($urandom), 13'($urandom), 16'($urandom_range(0, 7)),
                pick_addr(DEF_SRC, ALT_SRC), pick_addr(DEF_DST, ALT_DST),
                $urandom_range(0, 12), 32'($urandom),
                ($urandom_range(0, 1) != 0) ? -1 : int'($urandom_range(0, 65535)));
    if ($urandom_range(0, 1) != 0) begin
      n = $urandom_range(1, frame_q.size());
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
    send_frame();
  endtask

  // ---------------- directed table ----------------
  dir_row_t dir_tab [23] = '{
    '{K_SHORT, 5, 1'b0, 0,    0,  20,    KEY_A, 1'b1, gdfr_pkg::V_NOTGRE},
    '{K_ETH,   5, 1'b0, 0,    0,  0,     KEY_A, 1'b1, gdfr_pkg::V_NOTGRE},
    '{K_PROTO, 5, 1'b0, 0,    0,  0,     KEY_A, 1'b1, gdfr_pkg::V_NOTGRE},
    '{K_GRE,   5, 1'b0, 0,    7,  12,    KEY_A, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_READ,  0, 1'b0, 0,    4,  10,    '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_READ,  0, 1'b0, 0,    7,  16383, '0,    1'b1, gdfr_pkg::V_DUMPED},
    '{K_GRE,   3, 1'b0, 0,    7,  12,    KEY_B, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    1,  8,     KEY_A, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    1,  8,     KEY_B, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 2,    1,  8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 4,    1,  8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 3,    99, 8,     '0,    1'b1, gdfr_pkg::V_ORPHAN},
    '{K_GRE,   5, 1'b1, 0,    10, 0,     KEY_A, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    11, 0,     KEY_A, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    12, 0,     KEY_B, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    13, 0,     KEY_B, 1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b1, 0,    14, 0,     KEY_A, 1'b1, gdfr_pkg::V_FULL},
    '{K_GRE,   5, 1'b1, 2047, 10, 8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_READ,  0, 1'b0, 0,    0,  16383, '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 8191, 10, 8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 8191, 11, 8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 8191, 12, 8,     '0,    1'b0, gdfr_pkg::V_DUMPED},
    '{K_GRE,   5, 1'b0, 8191, 13, 8,     '0,    1'b0, gdfr_pkg::V_DUMPED}
  };

  logic [31:0] phase_cfg [6][3] = '{
    '{gdfr_pkg::ALL_ONES, gdfr_pkg::ALL_ONES, 32'h0},
    '{DEF_SRC,            gdfr_pkg::ALL_ONES, KEY_A},
    '{gdfr_pkg::ALL_ONES, DEF_DST,            32'h0},
    '{32'h0,              gdfr_pkg::ALL_ONES, gdfr_pkg::ALL_ONES},
    '{gdfr_pkg::ALL_ONES, gdfr_pkg::ALL_ONES, KEY_B},
    '{DEF_SRC,            DEF_DST,            32'h0}
  };

  // ---------------- clock, reset, limit ----------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(64'd60_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------- result side ----------------
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      n = hold_req ? 400 : (quiet ? 0 : $urandom_range(0, 17));
      hold_req = 1'b0;
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat, actual v=%0d s=%0d len=%0d rd=%0d", $time,
                 verdict_o, slot_o, payload_length_o, read_data_o);
        errors++;
      end else begin
        mon_exp = verdict_q.pop_front();
        if (verdict_o !== mon_exp.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, mon_exp.verdict, verdict_o);
          errors++;
        end
        if (slot_o !== mon_exp.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, mon_exp.slot, slot_o);
          errors++;
        end
        if (payload_length_o !== mon_exp.plen) begin
          $display("%0t: length expected %0d actual %0d", $time, mon_exp.plen, payload_length_o);
          errors++;
        end
        if (read_data_o !== mon_exp.rdata) begin
          $display("%0t: read data expected %0h actual %0h", $time, mon_exp.rdata, read_data_o);
          errors++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int       i, ph, beats0;
    dir_row_t row;
    errors = 0; beats_sent = 0;
    quiet = 1'b0; hold_req = 1'b0; typed_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; action_i = 1'b0; data_byte_i = '0; last_byte_i = 1'b0;
    read_slot_i = '0; read_offset_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = gdfr_pkg::CFG_SRC; cfg_data_i = '0;
    f_src = gdfr_pkg::ALL_ONES; f_dst = gdfr_pkg::ALL_ONES; f_key = '0;
    bpos = 0; cur = 0; fstat = gdfr_pkg::ST_HEADER; fcls = gdfr_pkg::CL_UNFRAG;
    fbase = 0; pstart = 0; pend = 0; pcnt = 0;
    for (i = 12; i <= 33; i++) hdr_b[i] = '0;
    for (i = 0; i < SLOTS; i++) sv[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    write_reg(gdfr_pkg::CFG_SRC, gdfr_pkg::ALL_ONES);
    write_reg(gdfr_pkg::CFG_DST, gdfr_pkg::ALL_ONES);
    write_reg(gdfr_pkg::CFG_KEY, '0);

    for (i = 0; i < 23; i++) begin
      row = dir_tab[i];
      typed_on  = row.has_exp;
      typed_res = '{row.exp_v, 3'd0, 16'd0, 8'd0};
      if (row.kind == K_READ) begin
        send_beat(1'b1, 8'hff, 1'b1, 3'(row.ident), 14'(row.plen));
      end else begin
        build_frame((row.kind == K_ETH) ? 16'h86dd : gdfr_pkg::ETH_IPV4,
                    (row.kind == K_PROTO) ? 8'd6 : gdfr_pkg::PROTO_GRE, 4'(row.ihl), row.mf,
                    13'(row.fo), 16'(row.ident), DEF_SRC, DEF_DST, row.plen, row.key, -1);
        if (row.kind == K_SHORT)
          while (frame_q.size() > row.plen) void'(frame_q.pop_back());
        send_frame();
      end
      typed_on = 1'b0;
    end

    for (ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(gdfr_pkg::CFG_SRC, phase_cfg[ph][0]);
      write_reg(gdfr_pkg::CFG_DST, phase_cfg[ph][1]);
      write_reg(gdfr_pkg::CFG_KEY, phase_cfg[ph][2]);
      // one long output hold-off so the input side backs up
      if (ph == 1) hold_req = 1'b1;
      beats0 = beats_sent;
      while (beats_sent - beats0 < 25) begin
        quiet = $urandom_range(0, 4) == 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: frag_packet();
          5, 6:          single_packet();
          7:             noise_frame();
          default:       repeat ($urandom_range(1, 4)) issue_read();
        endcase
      end
      quiet = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
